>>> src/sts_pkg.sv
package sts_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int Q_DEPTH_DEF  = 4;

    // scanner modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_COMMENT = 3'd1;
    localparam logic [2:0] M_NUM     = 3'd2;
    localparam logic [2:0] M_ID      = 3'd3;
    localparam logic [2:0] M_STR     = 3'd4;
    localparam logic [2:0] M_HASH    = 3'd5;

    // result events
    localparam logic [1:0] EV_BYTE = 2'd0;
    localparam logic [1:0] EV_DONE = 2'd1;
    localparam logic [1:0] EV_ERR  = 2'd2;
    localparam logic [1:0] EV_END  = 2'd3;

    // token kinds
    localparam logic [3:0] K_INT    = 4'd0;
    localparam logic [3:0] K_FLOAT  = 4'd1;
    localparam logic [3:0] K_ID     = 4'd2;
    localparam logic [3:0] K_STR    = 4'd3;
    localparam logic [3:0] K_BOOL   = 4'd4;
    localparam logic [3:0] K_LPAREN = 4'd5;
    localparam logic [3:0] K_RPAREN = 4'd6;
    localparam logic [3:0] K_QUOTE  = 4'd7;
    localparam logic [3:0] K_PERIOD = 4'd8;

    // characters
    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_EOT    = 8'hFF;
    localparam logic [7:0] C_NL     = 8'h0A;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_T      = 8'h74;
    localparam logic [7:0] C_F      = 8'h66;

    typedef logic [15:0] t_pos;

    typedef struct packed {
        logic [1:0] event_res;
        logic [3:0] kind;
        logic [7:0] byte_out;
        t_pos       row;
        t_pos       col;
        logic       last;
    } t_res;

    // results of one accepted byte; second slot is used only with the first
    typedef struct packed {
        logic v0;
        logic v1;
        t_res r0;
        t_res r1;
    } t_push;

endpackage

>>> src/sts_front.sv
module sts_front
    import sts_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_ch,
    output t_push      o_wr
);

    logic [2:0]          r_mode, n_mode;
    logic                r_dot, n_dot;
    logic [POS_BITS-1:0] r_line, n_line, r_col, n_col;
    logic [POS_BITS-1:0] r_srow, n_srow, r_scol, n_scol;

    logic       lead_v, idle_v, take_idle, is_end;
    t_res       lead, idle_res;
    logic [2:0] idle_mode;
    logic       idle_mark, idle_clr;
    t_push      wr;

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_id(input logic [7:0] c);
        return !(c == C_LPAREN || c == C_RPAREN || is_digit(c) || c == C_DQUOTE ||
                 c == C_SQUOTE || c == C_HASH || c == C_DOT || is_ws(c));
    endfunction

    function automatic t_res mk(input logic [1:0] ev, input logic [3:0] k,
                                input logic [7:0] b, input t_pos rw, input t_pos cl);
        t_res r;
        r.event_res = ev;
        r.kind      = k;
        r.byte_out  = b;
        r.row       = rw;
        r.col       = cl;
        r.last      = 1'b0;
        return r;
    endfunction

    // byte seen with no token open
    always_comb begin
        idle_v    = 1'b0;
        idle_mode = M_IDLE;
        idle_mark = 1'b1;
        idle_clr  = 1'b0;
        idle_res  = mk(EV_DONE, K_PERIOD, i_ch, t_pos'(r_line), t_pos'(r_col));
        if (is_ws(i_ch)) begin
            idle_mark = 1'b0;
        end else if (i_ch == C_SEMI) begin
            idle_mark = 1'b0;
            idle_mode = M_COMMENT;
        end else if (is_digit(i_ch)) begin
            idle_v            = 1'b1;
            idle_mode         = M_NUM;
            idle_clr          = 1'b1;
            idle_res.event_res = EV_BYTE;
            idle_res.kind     = K_INT;
        end else if (is_id(i_ch)) begin
            idle_v            = 1'b1;
            idle_mode         = M_ID;
            idle_res.event_res = EV_BYTE;
            idle_res.kind     = K_ID;
        end else if (i_ch == C_DQUOTE) begin
            idle_mode = M_STR;
        end else if (i_ch == C_HASH) begin
            idle_mode = M_HASH;
        end else if (i_ch == C_LPAREN) begin
            idle_v        = 1'b1;
            idle_res.kind = K_LPAREN;
        end else if (i_ch == C_RPAREN) begin
            idle_v        = 1'b1;
            idle_res.kind = K_RPAREN;
        end else if (i_ch == C_SQUOTE) begin
            idle_v        = 1'b1;
            idle_res.kind = K_QUOTE;
        end else begin
            idle_v = 1'b1;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_dot     = r_dot;
        n_line    = r_line;
        n_col     = r_col;
        n_srow    = r_srow;
        n_scol    = r_scol;
        lead_v    = 1'b0;
        take_idle = 1'b0;
        is_end    = (i_ch == C_NUL) || (i_ch == C_EOT);
        lead      = mk(EV_DONE, r_dot ? K_FLOAT : K_INT, 8'h00,
                       t_pos'(r_srow), t_pos'(r_scol));
        wr        = '0;

        if (is_end) begin
            unique case (r_mode)
                M_NUM: begin
                    lead_v = 1'b1;
                end
                M_ID: begin
                    lead_v    = 1'b1;
                    lead.kind = K_ID;
                end
                M_STR: begin
                    lead_v         = 1'b1;
                    lead.event_res = EV_ERR;
                    lead.kind      = K_STR;
                end
                M_HASH: begin
                    lead_v         = 1'b1;
                    lead.event_res = EV_ERR;
                    lead.kind      = K_BOOL;
                end
                default: begin
                end
            endcase
            n_mode = M_IDLE;
            n_dot  = 1'b0;
            n_line = POS_BITS'(1);
            n_col  = POS_BITS'(1);
            n_srow = '0;
            n_scol = '0;
        end else begin
            unique case (r_mode)
                M_COMMENT: begin
                    if (i_ch == C_NL) begin
                        n_mode = M_IDLE;
                    end
                end
                M_NUM: begin
                    lead_v = 1'b1;
                    if (is_digit(i_ch) || (i_ch == C_DOT && !r_dot)) begin
                        n_dot          = r_dot | (i_ch == C_DOT);
                        lead.event_res = EV_BYTE;
                        lead.kind      = n_dot ? K_FLOAT : K_INT;
                        lead.byte_out  = i_ch;
                    end else begin
                        take_idle = 1'b1;
                    end
                end
                M_ID: begin
                    lead_v    = 1'b1;
                    lead.kind = K_ID;
                    if (is_id(i_ch)) begin
                        lead.event_res = EV_BYTE;
                        lead.byte_out  = i_ch;
                    end else begin
                        take_idle = 1'b1;
                    end
                end
                M_STR: begin
                    lead_v    = 1'b1;
                    lead.kind = K_STR;
                    if (i_ch == C_DQUOTE) begin
                        n_mode = M_IDLE;
                    end else begin
                        lead.event_res = EV_BYTE;
                        lead.byte_out  = i_ch;
                    end
                end
                M_HASH: begin
                    lead_v        = 1'b1;
                    lead.kind     = K_BOOL;
                    lead.byte_out = i_ch;
                    if (i_ch == C_T || i_ch == C_F) begin
                        n_mode = M_IDLE;
                    end else begin
                        lead.event_res = EV_ERR;
                        take_idle      = 1'b1;
                    end
                end
                default: begin
                    take_idle = 1'b1;
                end
            endcase

            if (take_idle) begin
                n_mode = idle_mode;
                if (idle_clr) begin
                    n_dot = 1'b0;
                end
                if (idle_mark) begin
                    n_srow = r_line;
                    n_scol = r_col;
                end
            end

            if (i_ch == C_NL) begin
                if (r_line != '1) begin
                    n_line = r_line + POS_BITS'(1);
                end
                n_col = POS_BITS'(1);
            end else if (r_col != '1) begin
                n_col = r_col + POS_BITS'(1);
            end
        end

        // pack lead and trailing result into the two slots
        if (is_end) begin
            wr.v0 = 1'b1;
            wr.v1 = lead_v;
            wr.r0 = lead_v ? lead : mk(EV_END, K_INT, 8'h00, t_pos'(r_line), t_pos'(r_col));
            wr.r1 = mk(EV_END, K_INT, 8'h00, t_pos'(r_line), t_pos'(r_col));
        end else begin
            wr.v0 = lead_v | (take_idle & idle_v);
            wr.v1 = lead_v & take_idle & idle_v;
            wr.r0 = lead_v ? lead : idle_res;
            wr.r1 = idle_res;
        end
        wr.r0.last = !wr.v1;
        wr.r1.last = 1'b1;
        if (!i_accept) begin
            wr.v0 = 1'b0;
            wr.v1 = 1'b0;
        end
    end

    assign o_wr = wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_dot  <= 1'b0;
            r_line <= POS_BITS'(1);
            r_col  <= POS_BITS'(1);
            r_srow <= '0;
            r_scol <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_dot  <= n_dot;
            r_line <= n_line;
            r_col  <= n_col;
            r_srow <= n_srow;
            r_scol <= n_scol;
        end
    end

endmodule

>>> src/sts_queue.sv
module sts_queue
    import sts_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_wr,
    input  logic  i_pop,
    output t_res  o_head,
    output logic  o_empty,
    output logic  o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_res          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr, r_rd, n_rd, w1;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          pop_ok;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_empty = (r_cnt == '0);
    // room for the two results one byte can cause
    assign o_full  = (r_cnt > CW'(DEPTH - 2));
    assign o_head  = r_mem[r_rd];
    assign pop_ok  = i_pop && !o_empty;
    assign w1      = inc(r_wr);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = pop_ok ? inc(r_rd) : r_rd;
        n_cnt = r_cnt - CW'(pop_ok);
        if (i_wr.v1) begin
            n_wr  = inc(w1);
            n_cnt = n_cnt + CW'(2);
        end else if (i_wr.v0) begin
            n_wr  = w1;
            n_cnt = n_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.v0) begin
            r_mem[r_wr] <= i_wr.r0;
        end
        if (i_wr.v1) begin
            r_mem[w1] <= i_wr.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> src/sexpr_token_scanner.sv
// Channel   Direction  Handshake           Beat content
// -------   ---------  ------------------  -------------------------------------------
// source    in         push / full         i_ch: one text byte
// result    out        empty / pop         event, kind, byte, row, col, last flag
//
// Cycles: one byte is taken every cycle while full is low; the scanner state
// updates in that same cycle and its results land in the result queue.
// Results wait in the result queue behind older ones; the head drives the outputs.
// The queue drains one beat per cycle while pop is high, so a run of bytes that
// each give two results (a token end plus a new token) fills it and raises full.
// Reset: synchronous, active low; clears the scanner state and empties the queue.
// Stalls: full is raised whenever the queue lacks room for two beats.
module sexpr_token_scanner
    import sts_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int Q_DEPTH  = Q_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  o_event_res,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_byte_out,
    output logic [15:0] o_row,
    output logic [15:0] o_col,
    output logic        o_last
);

    logic  accept;
    t_push wr;
    t_res  head;

    // take a byte only when the queue can hold everything it may cause
    assign accept = push && !full;

    // front: mode tracking, position counting and result generation
    sts_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (i_ch),
        .o_wr     (wr)
    );

    // back: hold results until the consumer pops them
    sts_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    assign o_event_res = head.event_res;
    assign o_kind      = head.kind;
    assign o_byte_out  = head.byte_out;
    assign o_row       = head.row;
    assign o_col       = head.col;
    assign o_last      = head.last;

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import sts_pkg::*;

    // Run limits: the slowest legal run is well under a fifth of this.
    localparam int unsigned RUN_LIMIT_NS = 15_000_000;
    localparam int          DRAIN_LIMIT  = 20_000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          PHASE_BYTES  = 400;
    localparam int          PRINT_CAP    = 40;

    // One beat offered to the scanner, with up to two results typed in by hand.
    // n_typed of zero leaves the expectation to the predictor.
    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] n_typed;
        t_res       r0;
        t_res       r1;
    } t_beat;

    localparam t_res NO_RES = '0;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic [7:0]  i_ch    = 8'h00;
    logic        pop     = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  o_event_res;
    logic [3:0]  o_kind;
    logic [7:0]  o_byte_out;
    logic [15:0] o_row;
    logic [15:0] o_col;
    logic        o_last;

    sexpr_token_scanner DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_ch        (i_ch),
        .pop         (pop),
        .empty       (empty),
        .o_event_res (o_event_res),
        .o_kind      (o_kind),
        .o_byte_out  (o_byte_out),
        .o_row       (o_row),
        .o_col       (o_col),
        .o_last      (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Bytes still to be offered, and results the scanner owes us, oldest first.
    t_beat text_feed[$];
    t_res  pending_results[$];

    // Idling mix of the current phase, in percent; written at the falling edge.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Long receiver hold-off: bump hold_req and the counter below does the rest.
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int full_cycles    = 0;

    // ------------------------------------------------------------------
    // Scanner predictor: own copy of the tokeniser state.
    // ------------------------------------------------------------------
    logic [2:0] scan_mode;
    logic       scan_dot;
    t_pos       line_no;
    t_pos       col_no;
    t_pos       tok_row;
    t_pos       tok_col;

    // results of the byte just scanned
    t_res step_res[2];
    int   step_n;

    t_beat beat;

    function automatic t_res mk_res(input logic [1:0] ev, input logic [3:0] k,
                                    input logic [7:0] b, input t_pos r, input t_pos c,
                                    input logic lst);
        t_res x;
        x.event_res = ev;
        x.kind      = k;
        x.byte_out  = b;
        x.row       = r;
        x.col       = c;
        x.last      = lst;
        return x;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Anything that is not a delimiter, digit, quote, hash, dot or blank.
    function automatic bit may_join_ident(input logic [7:0] c);
        return !(c == C_LPAREN || c == C_RPAREN || is_numeral(c) || c == C_DQUOTE ||
                 c == C_SQUOTE || c == C_HASH || c == C_DOT || is_space(c));
    endfunction

    function automatic logic [3:0] num_kind();
        return scan_dot ? K_FLOAT : K_INT;
    endfunction

    function automatic void scan_reset();
        scan_mode = M_IDLE;
        scan_dot  = 1'b0;
        line_no   = 16'd1;
        col_no    = 16'd1;
        tok_row   = 16'd0;
        tok_col   = 16'd0;
    endfunction

    function automatic void emit_res(input logic [1:0] ev, input logic [3:0] k,
                                     input logic [7:0] b, input t_pos r, input t_pos c);
        step_res[step_n] = mk_res(ev, k, b, r, c, 1'b0);
        step_n++;
    endfunction

    // A byte seen with no token open: blanks drop, ';' opens a comment,
    // everything else marks a token start at the current position.
    function automatic void scan_idle(input logic [7:0] c);
        scan_mode = M_IDLE;
        if (c == C_SEMI) begin
            scan_mode = M_COMMENT;
        end else if (!is_space(c)) begin
            tok_row = line_no;
            tok_col = col_no;
            if (is_numeral(c)) begin
                scan_mode = M_NUM;
                scan_dot  = 1'b0;
                emit_res(EV_BYTE, K_INT, c, tok_row, tok_col);
            end else if (may_join_ident(c)) begin
                scan_mode = M_ID;
                emit_res(EV_BYTE, K_ID, c, tok_row, tok_col);
            end else if (c == C_DQUOTE) begin
                scan_mode = M_STR;
            end else if (c == C_HASH) begin
                scan_mode = M_HASH;
            end else if (c == C_LPAREN) begin
                emit_res(EV_DONE, K_LPAREN, c, tok_row, tok_col);
            end else if (c == C_RPAREN) begin
                emit_res(EV_DONE, K_RPAREN, c, tok_row, tok_col);
            end else if (c == C_SQUOTE) begin
                emit_res(EV_DONE, K_QUOTE, c, tok_row, tok_col);
            end else begin
                emit_res(EV_DONE, K_PERIOD, c, tok_row, tok_col);
            end
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        step_n = 0;
        if (c == C_NUL || c == C_EOT) begin
            // close whatever is open, then report the end and start afresh
            case (scan_mode)
                M_NUM:   emit_res(EV_DONE, num_kind(), 8'h00, tok_row, tok_col);
                M_ID:    emit_res(EV_DONE, K_ID, 8'h00, tok_row, tok_col);
                M_STR:   emit_res(EV_ERR, K_STR, 8'h00, tok_row, tok_col);
                M_HASH:  emit_res(EV_ERR, K_BOOL, 8'h00, tok_row, tok_col);
                default: ;
            endcase
            // kind reads zero on the end beat
            emit_res(EV_END, K_INT, 8'h00, line_no, col_no);
            scan_reset();
        end else begin
            case (scan_mode)
                M_COMMENT: begin
                    if (c == C_NL)
                        scan_mode = M_IDLE;
                end
                M_NUM: begin
                    if (is_numeral(c) || (c == C_DOT && !scan_dot)) begin
                        if (c == C_DOT)
                            scan_dot = 1'b1;
                        emit_res(EV_BYTE, num_kind(), c, tok_row, tok_col);
                    end else begin
                        emit_res(EV_DONE, num_kind(), 8'h00, tok_row, tok_col);
                        scan_idle(c);
                    end
                end
                M_ID: begin
                    if (may_join_ident(c)) begin
                        emit_res(EV_BYTE, K_ID, c, tok_row, tok_col);
                    end else begin
                        emit_res(EV_DONE, K_ID, 8'h00, tok_row, tok_col);
                        scan_idle(c);
                    end
                end
                M_STR: begin
                    if (c == C_DQUOTE) begin
                        emit_res(EV_DONE, K_STR, 8'h00, tok_row, tok_col);
                        scan_mode = M_IDLE;
                    end else begin
                        emit_res(EV_BYTE, K_STR, c, tok_row, tok_col);
                    end
                end
                M_HASH: begin
                    if (c == C_T || c == C_F) begin
                        emit_res(EV_DONE, K_BOOL, c, tok_row, tok_col);
                        scan_mode = M_IDLE;
                    end else begin
                        // bad hash: flag it, then treat the byte afresh
                        emit_res(EV_ERR, K_BOOL, c, tok_row, tok_col);
                        scan_idle(c);
                    end
                end
                default: scan_idle(c);
            endcase
            // advance the position, pinning both counters at all-ones
            if (c == C_NL) begin
                if (line_no != 16'hFFFF)
                    line_no++;
                col_no = 16'd1;
            end else if (col_no != 16'hFFFF) begin
                col_no++;
            end
        end
        if (step_n > 0)
            step_res[step_n - 1].last = 1'b1;
    endfunction

    initial scan_reset();

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_row(input logic [7:0] ch, input logic [1:0] n,
                                    input t_res r0, input t_res r1);
        t_beat b;
        b.ch      = ch;
        b.n_typed = n;
        b.r0      = r0;
        b.r1      = r1;
        text_feed.push_back(b);
    endfunction

    function automatic void add_text(input logic [7:0] ch);
        add_row(ch, 2'd0, NO_RES, NO_RES);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(9));
    endfunction

    // Random byte from 1..254 that may sit in an identifier; no ';' at its head.
    function automatic logic [7:0] rand_ident_char(input bit head);
        logic [7:0] b;
        b = 8'($urandom_range(254, 1));
        while (!may_join_ident(b) || (head && b == C_SEMI))
            b = 8'($urandom_range(254, 1));
        return b;
    endfunction

    // Random byte from 1..254 other than the one given.
    function automatic logic [7:0] rand_byte_but(input logic [7:0] x);
        logic [7:0] b;
        b = 8'($urandom_range(254, 1));
        while (b == x)
            b = 8'($urandom_range(254, 1));
        return b;
    endfunction

    // Append one random lexeme: mostly well-formed tokens with random content,
    // the rest blanks, comments, noise, open strings, bad hashes and end-of-text bytes.
    function automatic void add_lexeme();
        int pick;
        int n;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 14) begin
            n = $urandom_range(4, 1);
            for (int i = 0; i < n; i++)
                add_text(rand_digit());
        end else if (pick < 22) begin
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++)
                add_text(rand_digit());
            add_text(C_DOT);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++)
                add_text(rand_digit());
            if ($urandom_range(3) == 0)
                add_text(C_DOT);
        end else if (pick < 40) begin
            n = $urandom_range(6, 1);
            for (int i = 0; i < n; i++)
                add_text(rand_ident_char(i == 0));
        end else if (pick < 50) begin
            add_text(C_DQUOTE);
            n = $urandom_range(6);
            for (int i = 0; i < n; i++)
                add_text(rand_byte_but(C_DQUOTE));
            if ($urandom_range(9) != 0)
                add_text(C_DQUOTE);
        end else if (pick < 56) begin
            add_text(C_HASH);
            add_text($urandom_range(1) ? C_T : C_F);
        end else if (pick < 60) begin
            add_text(C_HASH);
            b = rand_byte_but(C_T);
            while (b == C_F)
                b = rand_byte_but(C_T);
            add_text(b);
        end else if (pick < 72) begin
            case ($urandom_range(3))
                0:       add_text(C_LPAREN);
                1:       add_text(C_RPAREN);
                2:       add_text(C_SQUOTE);
                default: add_text(C_DOT);
            endcase
        end else if (pick < 85) begin
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++)
                add_text(($urandom_range(6) == 0) ? 8'h20 : 8'($urandom_range(8'h0D, 8'h09)));
        end else if (pick < 90) begin
            add_text(C_SEMI);
            n = $urandom_range(8);
            for (int i = 0; i < n; i++)
                add_text(rand_byte_but(C_NL));
            add_text(C_NL);
        end else if (pick < 97) begin
            add_text(8'($urandom_range(254, 1)));
        end else begin
            add_text($urandom_range(1) ? C_EOT : C_NUL);
        end
    endfunction

    task automatic report_mismatch(input string what, input int unsigned seen,
                                   input int unsigned wanted);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] MISMATCH %s: got 'h%0h, want 'h%0h (result %0d)",
                     $realtime, what, seen, wanted, results_seen);
    endtask

    // Hold until every byte is taken and every owed result has arrived or the drain limit runs out.
    task automatic drain_all();
        int k;
        while (text_feed.size() != 0)
            @(negedge i_clk);
        k = 0;
        while (pending_results.size() != 0 && k < DRAIN_LIMIT) begin
            @(negedge i_clk);
            k++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver hold-off counter, in a process of its own.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end
    end

    // ------------------------------------------------------------------
    // Beat engine: check the result side first, then book the byte side,
    // so a result and a fresh byte on the same edge never race.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            if (full)
                full_cycles++;

            // result side
            if (pop && !empty) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing owed, event",
                                    32'(o_event_res), 0);
                end else begin
                    if (o_event_res !== pending_results[0].event_res)
                        report_mismatch("event", 32'(o_event_res),
                                        32'(pending_results[0].event_res));
                    if (o_kind !== pending_results[0].kind)
                        report_mismatch("kind", 32'(o_kind), 32'(pending_results[0].kind));
                    if (o_byte_out !== pending_results[0].byte_out)
                        report_mismatch("byte", 32'(o_byte_out),
                                        32'(pending_results[0].byte_out));
                    if (o_row !== pending_results[0].row)
                        report_mismatch("row", 32'(o_row), 32'(pending_results[0].row));
                    if (o_col !== pending_results[0].col)
                        report_mismatch("col", 32'(o_col), 32'(pending_results[0].col));
                    if (o_last !== pending_results[0].last)
                        report_mismatch("last", 32'(o_last), 32'(pending_results[0].last));
                    void'(pending_results.pop_front());
                end
            end
            // drop pop for the whole hold-off, else stall at the phase's rate
            pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);

            // byte side: a beat taken here is predicted at once
            if (push && !full) begin
                beat = text_feed.pop_front();
                scan_byte(beat.ch);
                bytes_sent++;
                if (beat.n_typed != 0) begin
                    pending_results.push_back(beat.r0);
                    if (beat.n_typed == 2)
                        pending_results.push_back(beat.r1);
                end else begin
                    for (int i = 0; i < step_n; i++)
                        pending_results.push_back(step_res[i]);
                end
            end
            if (text_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                push <= 1'b1;
                i_ch <= text_feed[0].ch;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence; reset is released on a rising edge, all later writes land on the falling edge.
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed walk from reset. Typed rows: first beat after reset, the
        // bad-hash error, an open string cut by NUL, a pending hash cut by 0xFF.
        add_row(C_LPAREN, 2'd1, mk_res(EV_DONE, K_LPAREN, C_LPAREN, 16'd1, 16'd1, 1'b1),
                NO_RES);
        add_text(C_RPAREN);
        add_text(C_SQUOTE);
        add_text(C_DOT);
        add_text(" ");
        add_text("1");
        add_text(C_DOT);                 // number turns float
        add_text("5");
        add_text(C_DOT);                 // second dot ends it and stands alone
        add_text(C_HASH);
        add_text(C_T);
        add_text(C_HASH);
        add_row("x", 2'd2, mk_res(EV_ERR, K_BOOL, "x", 16'd1, 16'd12, 1'b0),
                mk_res(EV_BYTE, K_ID, "x", 16'd1, 16'd13, 1'b1));
        add_text(C_SEMI);                // inside an identifier, not a comment
        add_text(C_NL);
        add_text(C_SEMI);
        add_text("z");
        add_text(C_NL);
        add_text(C_DQUOTE);
        add_text(8'h80);
        add_row(C_NUL, 2'd2, mk_res(EV_ERR, K_STR, 8'h00, 16'd3, 16'd1, 1'b0),
                mk_res(EV_END, K_INT, 8'h00, 16'd3, 16'd3, 1'b1));
        add_text(C_HASH);
        add_row(C_EOT, 2'd2, mk_res(EV_ERR, K_BOOL, 8'h00, 16'd1, 16'd1, 1'b0),
                mk_res(EV_END, K_INT, 8'h00, 16'd1, 16'd2, 1'b1));
        add_text("9");
        add_text(C_EOT);                 // number closed by end of text
        add_text(8'hFE);
        add_text(C_DQUOTE);              // closes the identifier, opens a string
        add_text(C_DQUOTE);
        add_text(C_HASH);
        add_text(C_F);
        add_text("q");
        add_text(C_NUL);                 // identifier closed by end of text
        drain_all();

        // Random text under four idling mixes; pause between them until all
        // owed results are in.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase
            while (text_feed.size() < PHASE_BYTES)
                add_lexeme();
            drain_all();
        end

        // Back-pressure: hold the receiver off while digit/paren pairs, each
        // paren giving two results, pile up until full rises.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        for (int i = 0; i < 150; i++) begin
            add_text(rand_digit());
            add_text(C_LPAREN);
        end
        add_text(C_NUL);
        drain_all();

        // Tail: let any stray result show, then settle the verdict.
        repeat (20) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 32'(pending_results.size()), 0);

        $display("Scanned %0d bytes into %0d checked results; %0d cycles with input full.",
                 bytes_sent, results_seen, full_cycles);
        $display("Covered a directed token walk, four idling mixes and a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d bytes and %0d results outstanding",
                 text_feed.size(), pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
